// ===== src/apq_pkg.sv =====
// Package for the ascending priority queue: operation and status codes,
// value width and the control bundle handed to the cell chain.
// No dependencies.
`default_nettype none

package apq_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;  // place the broadcast value in sorted position
    logic rem;  // shift the whole row one cell toward the head
  } apq_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ascending_priority_queue.sv =====
// Ascending priority queue top level: cell row, entry counter, operation
// decode and output register. Depends on apq_pkg and apq_cell.
`default_nettype none

// The queue takes one operation per clock cycle when not stalled and shows
// its result in the cycle after it is accepted; the output register frees
// the input side again in the cycle the result is taken. Values are kept in a
// row of CAPACITY cells sorted ascending, so the minimum always sits in the
// head cell: an insert is compared against every occupied cell at once and
// the larger entries move one cell to the right, and a remove moves the
// whole row one cell to the left. Cell occupancy follows from the entry
// counter alone, so nothing needs clearing after reset.
module ascending_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] min_value, [36:32] entry_count
  output logic [1:0]       m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned VW   = apq_pkg::ValW;
  localparam int unsigned OW   = apq_pkg::CountW;

  logic                 accept;
  logic [CntW-1:0]      cnt_q, cnt_d;
  apq_pkg::apq_ctrl_t   ctrl;
  logic signed [VW-1:0] ins_val;

  logic                 out_valid_q;
  apq_pkg::status_e     status_q, status_d;
  logic signed [VW-1:0] min_q, min_d;
  logic [OW-1:0]        count_q;
  logic [CntW+OW-1:0]   cnt_ext;

  logic [CAPACITY-1:0]        occ;
  logic [CAPACITY-1:0]        gt;
  logic signed [VW-1:0]       cell_val [CAPACITY];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign ins_val         = s_axis_tdata_i[VW-1:0];

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_gt;
    logic signed [VW-1:0] prev_val;
    logic signed [VW-1:0] next_val;

    assign occ[i] = cnt_q > CntW'(i);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = ins_val;
    end else begin : g_body
      assign prev_gt  = gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    apq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .ins_val_i  (ins_val),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .gt_o       (gt[i]),
      .val_o      (cell_val[i])
    );
  end

  // Operation decode
  always_comb begin
    ctrl     = '0;
    cnt_d    = cnt_q;
    status_d = apq_pkg::ST_OK;
    min_d    = '0;
    if (accept) begin
      unique case (apq_pkg::mode_e'(s_axis_tuser_i))
        apq_pkg::MODE_INSERT: begin
          if (cnt_q == CntW'(CAPACITY)) begin
            status_d = apq_pkg::ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        apq_pkg::MODE_REMOVE: begin
          if (cnt_q == '0) begin
            status_d = apq_pkg::ST_EMPTY;
          end else begin
            ctrl.rem = 1'b1;
            min_d    = cell_val[0];
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        apq_pkg::MODE_PEEK: begin
          if (cnt_q == '0) begin
            status_d = apq_pkg::ST_EMPTY;
          end else begin
            min_d = cell_val[0];
          end
        end
        default: begin
          // unused code: no operation
        end
      endcase
    end
  end

  assign cnt_ext = {{OW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      min_q    <= min_d;
      count_q  <= cnt_ext[OW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {3'b000, count_q, min_q};

endmodule

`default_nettype wire

// ===== src/apq_cell.sv =====
// One cell of the sorted queue row: holds one value and trades it with its
// neighbors on insert and remove. Depends on apq_pkg.
`default_nettype none

module apq_cell (
  input  wire logic                           clk_i,
  input  wire apq_pkg::apq_ctrl_t             ctrl_i,
  input  wire logic                           occ_i,
  input  wire logic signed [apq_pkg::ValW-1:0] ins_val_i,
  input  wire logic                           prev_gt_i,
  input  wire logic signed [apq_pkg::ValW-1:0] prev_val_i,
  input  wire logic signed [apq_pkg::ValW-1:0] next_val_i,
  output logic                                gt_o,
  output logic signed [apq_pkg::ValW-1:0]     val_o
);

  logic signed [apq_pkg::ValW-1:0] val_q, val_d;

  // Empty cells, and cells holding a larger value, sit at or past the slot
  // the new value belongs in.
  assign gt_o  = !occ_i || (val_q > ins_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.rem) begin
      val_d = next_val_i;
    end else if (ctrl_i.ins && gt_o) begin
      // First cell past the slot takes the new value, the rest move right.
      val_d = prev_gt_i ? prev_val_i : ins_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== src/apq_checker.sv =====
// Port-level checker for the ascending priority queue, bound to the top
// level. Depends on apq_pkg and ascending_priority_queue.
`default_nettype none

module apq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [31:0] s_axis_tdata_i,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  localparam logic [4:0] CapLow = 5'(CAPACITY);

  // Every accepted transaction leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after accepted transaction");

  // Underflow reports an empty queue and no value.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == apq_pkg::ST_EMPTY
      |-> m_axis_tdata_o[36:0] == 37'd0)
    else $error("underflow result carries data");

  // A full status reports a full queue and no value.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == apq_pkg::ST_FULL
      |-> m_axis_tdata_o[36:32] == CapLow && m_axis_tdata_o[31:0] == 32'd0)
    else $error("full result inconsistent");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
      |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind ascending_priority_queue apq_checker #(.CAPACITY(CAPACITY)) u_apq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
